// ===== design/shah_pkg.sv =====
`default_nettype none
package shah_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned WIN_LEN  = 16;
   localparam int unsigned ROUNDS   = 64;
   localparam int unsigned HASH_LEN = 8;

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [5:0] LEN_FILL  = 6'd56;
   localparam logic [5:0] LAST_RND  = 6'd63;
   localparam logic [2:0] LAST_IDX  = 3'd7;

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] HASH_IV [HASH_LEN] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_ADD   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   // datapath controls issued by the sequencer
   typedef struct packed {
      logic       push;
      logic       push_word;
      logic [7:0] pbyte;
      logic       load;
      logic       step;
      logic       add;
      logic       init;
   } ctl_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] dbl;
      dbl  = {x, x} >> n;
      rotr = dbl[31:0];
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
   endfunction

endpackage
`default_nettype wire

// ===== design/shah_if.sv =====
`default_nettype none
interface shah_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source(output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
   modport sink(input valid, input data_byte, input byte_present,
                input end_of_message, output ready);
endinterface

interface shah_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source(output valid, output digest_word, output word_index,
                  output last_word, input ready);
   modport sink(input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface
`default_nettype wire

// ===== design/shah_sched.sv =====
`default_nettype none
module shah_sched (
   input  wire logic            clock,
   input  wire shah_pkg::ctl_type ctl,
   output logic [31:0]          w_cur
);
   import shah_pkg::*;

   logic [23:0] acc_ff;
   logic [23:0] acc_in;
   logic [31:0] win_ff [WIN_LEN];
   logic [31:0] new_word;
   logic [31:0] expand;
   logic        shift;

   // next schedule word from the sliding window of the last sixteen
   assign expand   = small_sig1(win_ff[14]) + win_ff[9] + small_sig0(win_ff[1]) + win_ff[0];
   assign new_word = ctl.push_word ? {acc_ff, ctl.pbyte} : expand;
   assign shift    = ctl.push_word | ctl.step;
   assign acc_in   = {acc_ff[15:0], ctl.pbyte};
   assign w_cur    = win_ff[0];

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         acc_ff <= acc_in;
      end
      if (shift) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[WIN_LEN - 1] <= new_word;
      end
   end

endmodule
`default_nettype wire

// ===== design/shah_round.sv =====
`default_nettype none
module shah_round (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire shah_pkg::ctl_type ctl,
   input  wire logic [5:0]        rnd,
   input  wire logic [31:0]       w_cur,
   output logic [31:0]            hash_vals [shah_pkg::HASH_LEN]
);
   import shah_pkg::*;

   logic [31:0] hash_ff [HASH_LEN];
   logic [31:0] v_ff    [HASH_LEN];
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + big_sig1(v_ff[4]) + ch + ROUND_K[rnd] + w_cur;
   assign t2  = big_sig0(v_ff[0]) + maj;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < HASH_LEN; i++) begin
            v_ff[i] <= hash_ff[i];
         end
      end else if (ctl.step) begin
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         for (int i = 0; i < HASH_LEN; i++) begin
            hash_ff[i] <= HASH_IV[i];
         end
      end else if (ctl.add) begin
         for (int i = 0; i < HASH_LEN; i++) begin
            hash_ff[i] <= hash_ff[i] + v_ff[i];
         end
      end
   end

   assign hash_vals = hash_ff;

endmodule
`default_nettype wire

// ===== design/sha256_byte_stream_hasher.sv =====
`default_nettype none
// SHA-256 over a byte stream.
// req_bus takes one message byte per beat (data_byte with byte_present set);
// end_of_message marks the last beat of a message, which may carry no byte
// to close an empty message. A beat with neither flag changes nothing.
// rsp_bus returns the digest as eight 32-bit beats, word_index 0 to 7,
// h0 first, last_word set on the eighth.
// Byte beats are taken while the block is idle; after the 64th byte of a
// block it is busy compressing: one round per cycle through the single
// round unit, then a fold of the result into the hash words.
// Ending a message pads one byte per cycle up to the block end, then
// compresses before the first digest beat. When the length field does not
// fit behind the pad byte, or the last byte fills a block, one more block of
// padding and compression is added.
// req_bus.ready is low during reset, padding, compression and digest output.
// If the receiver stalls, the current digest beat holds until taken.
// Synchronous reset restores the initial hash values and clears the byte
// and fill counts; the block is ready as soon as reset is low.
module sha256_byte_stream_hasher (
   input  wire logic   clock,
   input  wire logic   reset,
   shah_req_if.sink    req_bus,
   shah_rsp_if.source  rsp_bus
);
   import shah_pkg::*;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  idx_ff, idx_in;
   logic        eom_ff, eom_in;
   logic        pad80_ff, pad80_in;
   logic        len_ok_ff, len_ok_in;
   logic        final_ff, final_in;

   ctl_type     ctl;
   logic        req_acc;
   logic [31:0] w_cur;
   logic [31:0] hash_words [HASH_LEN];
   logic [63:0] len_bits;
   logic [63:0] len_shift;
   logic [7:0]  len_byte;

   assign req_bus.ready = (state_ff == ST_IDLE) && !reset;
   assign req_acc       = req_bus.valid & req_bus.ready;

   // length field is big-endian in the last eight bytes of the final block
   assign len_bits  = {count_ff, 3'b000};
   assign len_shift = len_bits << {fill_ff[2:0], 3'b000};
   assign len_byte  = len_shift[63:56];

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      rnd_in        = rnd_ff;
      idx_in        = idx_ff;
      eom_in        = eom_ff;
      pad80_in      = pad80_ff;
      len_ok_in     = len_ok_ff;
      final_in      = final_ff;
      ctl.push      = 1'b0;
      ctl.pbyte     = req_bus.data_byte;
      ctl.load      = 1'b0;
      ctl.step      = 1'b0;
      ctl.add       = 1'b0;
      ctl.init      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_bus.byte_present) begin
                  ctl.push = 1'b1;
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + 61'd1;
               end
               if (req_bus.byte_present && fill_ff == LAST_FILL) begin
                  ctl.load = 1'b1;
                  rnd_in   = '0;
                  eom_in   = req_bus.end_of_message;
                  state_in = ST_ROUND;
               end else if (req_bus.end_of_message) begin
                  eom_in   = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctl.push = 1'b1;
            fill_in  = fill_ff + 6'd1;
            pad80_in = 1'b1;
            if (!pad80_ff) begin
               ctl.pbyte = PAD_BYTE;
            end else if (len_ok_ff && fill_ff >= LEN_FILL) begin
               ctl.pbyte = len_byte;
            end else begin
               ctl.pbyte = 8'h00;
            end
            if (fill_ff == LAST_FILL) begin
               // block full: it is the last one only if it held the length
               ctl.load  = 1'b1;
               rnd_in    = '0;
               final_in  = len_ok_ff;
               len_ok_in = 1'b1;
               state_in  = ST_ROUND;
            end else if (!pad80_ff && fill_ff < LEN_FILL) begin
               len_ok_in = 1'b1;
            end
         end
         ST_ROUND: begin
            ctl.step = 1'b1;
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == LAST_RND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ctl.add = 1'b1;
            if (final_ff) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end else if (eom_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_bus.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_IDX) begin
                  ctl.init  = 1'b1;
                  fill_in   = '0;
                  count_in  = '0;
                  eom_in    = 1'b0;
                  pad80_in  = 1'b0;
                  len_ok_in = 1'b0;
                  final_in  = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ctl.push_word = ctl.push & (fill_ff[1:0] == 2'b11);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         count_ff  <= '0;
         rnd_ff    <= '0;
         idx_ff    <= '0;
         eom_ff    <= 1'b0;
         pad80_ff  <= 1'b0;
         len_ok_ff <= 1'b0;
         final_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         rnd_ff    <= rnd_in;
         idx_ff    <= idx_in;
         eom_ff    <= eom_in;
         pad80_ff  <= pad80_in;
         len_ok_ff <= len_ok_in;
         final_ff  <= final_in;
      end
   end

   shah_sched u_sched (
      .clock (clock),
      .ctl   (ctl),
      .w_cur (w_cur)
   );

   shah_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rnd       (rnd_ff),
      .w_cur     (w_cur),
      .hash_vals (hash_words)
   );

   assign rsp_bus.valid       = (state_ff == ST_OUT);
   assign rsp_bus.digest_word = hash_words[idx_ff];
   assign rsp_bus.word_index  = idx_ff;
   assign rsp_bus.last_word   = (idx_ff == LAST_IDX);

endmodule
`default_nettype wire

// ===== design/shah_checker.sv =====
`default_nettype none
module shah_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_eom,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_word,
   input wire logic [2:0]  rsp_index,
   input wire logic        rsp_last
);
   import shah_pkg::*;

   // a stalled digest beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) && $stable(rsp_index))
      else $error("digest beat changed under stall");

   // no new bytes taken while the digest goes out
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken during digest output");

   // end of message starts padding or compression
   a_eom_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_eom |=> !req_ready)
      else $error("ready right after end of message");

   // digest words come out in order
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last
      |=> rsp_valid && (rsp_index == $past(rsp_index) + 3'd1))
      else $error("digest word order broken");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_index == LAST_IDX)))
      else $error("last_word does not match word_index");

endmodule

bind sha256_byte_stream_hasher shah_checker u_shah_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_eom   (req_bus.end_of_message),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_word  (rsp_bus.digest_word),
   .rsp_index (rsp_bus.word_index),
   .rsp_last  (rsp_bus.last_word)
);
`default_nettype wire
